// ----- rtl/uirb_pkg.sv -----
// Shared types and constants for the UART interrupt ring buffer.
`default_nettype none

package uirb_pkg;

  // Widths fixed by the transaction fields.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LevelW = 9;

  // Event codes carried in the cmd field of an input transaction.
  typedef enum logic [1:0] {
    CmdRxByte  = 2'd0,
    CmdTxReady = 2'd1,
    CmdRead    = 2'd2,
    CmdWrite   = 2'd3
  } cmd_e;

  // Request from the control logic to one ring.
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [ByteW-1:0] wdata;
  } ring_req_t;

  // Status returned by one ring.
  typedef struct packed {
    logic full;
    logic empty;
  } ring_sts_t;

endpackage

`default_nettype wire

// ----- rtl/uirb_in_if.sv -----
// Input channel: one event transaction with a valid/ready handshake.
`default_nettype none

interface uirb_in_if
  import uirb_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [1:0]       cmd;
  logic [ByteW-1:0] data;

  modport source (output valid, output cmd, output data, input ready);
  modport sink   (input valid, input cmd, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/uirb_out_if.sv -----
// Output channel: one result transaction with a valid/ready handshake.
`default_nettype none

interface uirb_out_if
  import uirb_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              line_valid;
  logic [ByteW-1:0]  line_byte;
  logic              read_valid;
  logic [ByteW-1:0]  read_byte;
  logic              tx_active;
  logic [LevelW-1:0] rx_level;
  logic [LevelW-1:0] tx_level;
  logic              dropped;

  modport source (
    output valid, output line_valid, output line_byte, output read_valid,
    output read_byte, output tx_active, output rx_level, output tx_level,
    output dropped, input ready
  );
  modport sink (
    input valid, input line_valid, input line_byte, input read_valid,
    input read_byte, input tx_active, input rx_level, input tx_level,
    input dropped, output ready
  );
endinterface

`default_nettype wire

// ----- rtl/uirb_ring.sv -----
// Byte ring: a synchronous memory with head and tail pointers and a fill count.
`default_nettype none

module uirb_ring
  import uirb_pkg::*;
#(
  parameter int unsigned Depth = 256,
  localparam int unsigned PtrW = $clog2(Depth),
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ring_req_t        req_i,
  output      ring_sts_t        sts_o,
  output      logic [CntW-1:0]  count_o,
  output      logic [ByteW-1:0] rd_data_o
);

  logic [ByteW-1:0] mem_q [Depth];
  logic [ByteW-1:0] rd_data_q;
  logic [PtrW-1:0]  head_q, head_d;
  logic [PtrW-1:0]  tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  // Pointer and count update; the caller never pushes a full ring or pops an
  // empty one, and never pushes and pops in the same cycle.
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (req_i.push) begin
      head_d  = ptr_next(head_q);
      count_d = count_q + CntW'(1);
    end
    if (req_i.pop) begin
      tail_d  = ptr_next(tail_q);
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Storage: one write port at the head, one registered read port at the tail.
  // The read data register holds its value until the next pop.
  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem_q[head_q] <= req_i.wdata;
    end
    if (req_i.pop) begin
      rd_data_q <= mem_q[tail_q];
    end
  end

  assign sts_o.full  = (count_q == CntW'(Depth));
  assign sts_o.empty = (count_q == '0);
  assign count_o     = count_q;
  assign rd_data_o   = rd_data_q;

endmodule

`default_nettype wire

// ----- rtl/uart_interrupt_ring_buffer.sv -----
// Top level of the UART interrupt ring buffer: event decode, rings and result stage.
//
// Each input transaction on req_i carries one event: a byte received from the
// line, a transmitter-ready event, a read request or a write request. Every
// event gives exactly one result transaction on rsp_o with the byte handed to
// the transmit line, the byte returned to a reader, the transmitter-active
// flag, both ring levels and a flag for a byte lost to a full ring.
// The accepting edge reads the ring memory into its data register and loads the
// middle stage; the result register is loaded from both once it is free, and
// the result is valid after it. One event is accepted every cycle while the
// receiver takes results.
// A memory entry is always written at an earlier edge than any read of it, so
// no forwarding is needed.
// Reset clears the pointers, the fill counts and the active flag at once; the
// memories need no clearing pass, since the fill counts keep unwritten entries
// from being read. When the receiver stalls, the result register holds; one
// more event may enter the middle stage, which then holds too, and req_i.ready
// stays low until the result is taken.
`default_nettype none

module uart_interrupt_ring_buffer
  import uirb_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 256
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  uirb_in_if.sink   req_i,
  uirb_out_if.source rsp_o
);

  localparam int unsigned CntW = $clog2(RING_DEPTH + 1);

  typedef struct packed {
    logic              line_valid;
    logic              line_from_mem;
    logic [ByteW-1:0]  line_byte;
    logic              read_valid;
    logic              tx_active;
    logic [LevelW-1:0] rx_level;
    logic [LevelW-1:0] tx_level;
    logic              dropped;
  } stage_t;

  typedef struct packed {
    logic              line_valid;
    logic [ByteW-1:0]  line_byte;
    logic              read_valid;
    logic [ByteW-1:0]  read_byte;
    logic              tx_active;
    logic [LevelW-1:0] rx_level;
    logic [LevelW-1:0] tx_level;
    logic              dropped;
  } result_t;

  ring_req_t        rx_req, tx_req;
  ring_sts_t        rx_sts, tx_sts;
  logic [CntW-1:0]  rx_cnt, tx_cnt;
  logic [CntW-1:0]  rx_after, tx_after;
  logic [CntW+LevelW-1:0] rx_ext, tx_ext;
  logic [ByteW-1:0] rx_rdata, tx_rdata;

  logic    sending_q, sending_d;
  logic    accept;
  logic    stg_adv;
  logic    stg_valid_q;
  stage_t  stg_q, stg_d;
  logic    out_valid_q;
  result_t out_q, out_d;

  // Handshake: the middle stage moves on whenever the result register is free.
  assign stg_adv     = !out_valid_q || rsp_o.ready;
  assign req_i.ready = !stg_valid_q || stg_adv;
  assign accept      = req_i.valid && req_i.ready;

  // Event decode: ring requests, flag update and the early result fields.
  always_comb begin
    rx_req    = '0;
    tx_req    = '0;
    sending_d = sending_q;
    stg_d     = '0;
    rx_req.wdata = req_i.data;
    tx_req.wdata = req_i.data;
    if (accept) begin
      case (cmd_e'(req_i.cmd))
        CmdRxByte: begin
          if (rx_sts.full) begin
            stg_d.dropped = 1'b1;
          end else begin
            rx_req.push = 1'b1;
          end
        end
        CmdTxReady: begin
          if (sending_q) begin
            if (tx_sts.empty) begin
              sending_d = 1'b0;
            end else begin
              tx_req.pop          = 1'b1;
              stg_d.line_valid    = 1'b1;
              stg_d.line_from_mem = 1'b1;
            end
          end
        end
        CmdRead: begin
          if (!rx_sts.empty) begin
            rx_req.pop       = 1'b1;
            stg_d.read_valid = 1'b1;
          end
        end
        CmdWrite: begin
          if (sending_q) begin
            if (tx_sts.full) begin
              stg_d.dropped = 1'b1;
            end else begin
              tx_req.push = 1'b1;
            end
          end else begin
            stg_d.line_valid = 1'b1;
            stg_d.line_byte  = req_i.data;
            sending_d        = 1'b1;
          end
        end
        default: begin
          stg_d = '0;
        end
      endcase
    end
    stg_d.tx_active = sending_d;
    stg_d.rx_level  = rx_ext[LevelW-1:0];
    stg_d.tx_level  = tx_ext[LevelW-1:0];
  end

  // Levels after this event, masked to the width of the level fields.
  assign rx_after = rx_cnt + CntW'(rx_req.push) - CntW'(rx_req.pop);
  assign tx_after = tx_cnt + CntW'(tx_req.push) - CntW'(tx_req.pop);
  assign rx_ext   = (CntW + LevelW)'(rx_after);
  assign tx_ext   = (CntW + LevelW)'(tx_after);

  uirb_ring #(
    .Depth (RING_DEPTH)
  ) u_rx_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (rx_req),
    .sts_o     (rx_sts),
    .count_o   (rx_cnt),
    .rd_data_o (rx_rdata)
  );

  uirb_ring #(
    .Depth (RING_DEPTH)
  ) u_tx_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (tx_req),
    .sts_o     (tx_sts),
    .count_o   (tx_cnt),
    .rd_data_o (tx_rdata)
  );

  // Result assembly: merge the memory read data into the staged fields.
  always_comb begin
    out_d.line_valid = stg_q.line_valid;
    out_d.line_byte  = stg_q.line_from_mem ? tx_rdata : stg_q.line_byte;
    out_d.read_valid = stg_q.read_valid;
    out_d.read_byte  = stg_q.read_valid ? rx_rdata : '0;
    out_d.tx_active  = stg_q.tx_active;
    out_d.rx_level   = stg_q.rx_level;
    out_d.tx_level   = stg_q.tx_level;
    out_d.dropped    = stg_q.dropped;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q   <= 1'b0;
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sending_q <= sending_d;
      if (req_i.ready) begin
        stg_valid_q <= accept;
      end
      if (stg_adv) begin
        out_valid_q <= stg_valid_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_q <= stg_d;
    end
    if (stg_adv && stg_valid_q) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.line_valid = out_q.line_valid;
  assign rsp_o.line_byte  = out_q.line_byte;
  assign rsp_o.read_valid = out_q.read_valid;
  assign rsp_o.read_byte  = out_q.read_byte;
  assign rsp_o.tx_active  = out_q.tx_active;
  assign rsp_o.rx_level   = out_q.rx_level;
  assign rsp_o.tx_level   = out_q.tx_level;
  assign rsp_o.dropped    = out_q.dropped;

  // A dropped byte never coincides with a byte handed out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_valid_q |-> !(stg_q.dropped && (stg_q.line_valid || stg_q.read_valid)))
    else $error("dropped flag set together with a delivered byte");

  // Bytes are only queued for transmission while the transmitter is active.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sending_q |-> tx_sts.empty)
    else $error("transmit ring holds bytes while the transmitter is idle");

  // A held result blocks new events until the stage behind it can move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_valid_q && !stg_adv) |-> !req_i.ready)
    else $error("event accepted while the result stage is stalled");

  // A memory read always has a staged result waiting for its data next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_req.pop || tx_req.pop) |=> stg_valid_q)
    else $error("ring read without a staged result");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the UART interrupt ring buffer: random and directed events.
`timescale 1ns / 100ps

module tb_top;
  import uirb_pkg::*;

  localparam int unsigned RingDepth  = 256;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxReports = 10;

  // Expected content of one result transaction.
  typedef struct packed {
    logic              line_valid;
    logic [ByteW-1:0]  line_byte;
    logic              read_valid;
    logic [ByteW-1:0]  read_byte;
    logic              tx_active;
    logic [LevelW-1:0] rx_level;
    logic [LevelW-1:0] tx_level;
    logic              dropped;
  } uart_result_t;

  // One entry of the event list; a drain entry holds the sender until all results are in.
  typedef struct {
    logic             drain;
    logic             calm;
    cmd_e             cmd;
    logic [ByteW-1:0] data;
  } uart_event_t;

  logic clk_i;
  logic rst_ni;

  uirb_in_if  req_if ();
  uirb_out_if rsp_if ();

  uart_interrupt_ring_buffer #(
    .RING_DEPTH(RingDepth)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Event list, results still owed by the block, and bookkeeping.
  uart_event_t  event_q[$];
  uart_result_t owed_results_q[$];
  int unsigned  err_count   = 0;
  int unsigned  cycle_count = 0;
  logic         event_taken = 1'b0;
  logic         drive_calm  = 1'b0;
  logic         calm_tail   = 1'b0;
  logic         draining    = 1'b0;
  int unsigned  src_gap     = 0;
  int unsigned  sink_gap    = 0;

  // Shadow copy of both rings and the transmitter-active flag.
  logic [ByteW-1:0] rx_mem [RingDepth];
  logic [ByteW-1:0] tx_mem [RingDepth];
  int unsigned      rx_wr_ptr = 0;
  int unsigned      rx_rd_ptr = 0;
  int unsigned      rx_fill   = 0;
  int unsigned      tx_wr_ptr = 0;
  int unsigned      tx_rd_ptr = 0;
  int unsigned      tx_fill   = 0;
  logic             tx_busy   = 1'b0;

  // Clock generation.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Applies one event to the shadow rings and returns the result it should give.
  function automatic uart_result_t apply_uart_event(cmd_e cmd, logic [ByteW-1:0] data);
    uart_result_t res;
    res = '0;
    case (cmd)
      CmdRxByte: begin
        if (rx_fill >= RingDepth) begin
          res.dropped = 1'b1;
        end else begin
          rx_mem[rx_wr_ptr] = data;
          rx_wr_ptr = (rx_wr_ptr + 1) % RingDepth;
          rx_fill++;
        end
      end
      CmdTxReady: begin
        // The event is masked while the transmitter is inactive.
        if (tx_busy) begin
          if (tx_fill == 0) begin
            tx_busy = 1'b0;
          end else begin
            res.line_valid = 1'b1;
            res.line_byte  = tx_mem[tx_rd_ptr];
            tx_rd_ptr = (tx_rd_ptr + 1) % RingDepth;
            tx_fill--;
          end
        end
      end
      CmdRead: begin
        if (rx_fill != 0) begin
          res.read_valid = 1'b1;
          res.read_byte  = rx_mem[rx_rd_ptr];
          rx_rd_ptr = (rx_rd_ptr + 1) % RingDepth;
          rx_fill--;
        end
      end
      default: begin
        if (tx_busy) begin
          if (tx_fill >= RingDepth) begin
            res.dropped = 1'b1;
          end else begin
            tx_mem[tx_wr_ptr] = data;
            tx_wr_ptr = (tx_wr_ptr + 1) % RingDepth;
            tx_fill++;
          end
        end else begin
          // An idle transmitter takes the byte straight away.
          res.line_valid = 1'b1;
          res.line_byte  = data;
          tx_busy = 1'b1;
        end
      end
    endcase
    res.tx_active = tx_busy;
    res.rx_level  = LevelW'(rx_fill);
    res.tx_level  = LevelW'(tx_fill);
    return res;
  endfunction

  // Lists every field in which the observed result differs from the expected one.
  function automatic string field_diffs(uart_result_t got, uart_result_t want);
    string s;
    s = "";
    if (got.line_valid !== want.line_valid)
      s = {s, $sformatf(" line_valid exp %0d got %0d", want.line_valid, got.line_valid)};
    if (got.line_byte !== want.line_byte)
      s = {s, $sformatf(" line_byte exp %02h got %02h", want.line_byte, got.line_byte)};
    if (got.read_valid !== want.read_valid)
      s = {s, $sformatf(" read_valid exp %0d got %0d", want.read_valid, got.read_valid)};
    if (got.read_byte !== want.read_byte)
      s = {s, $sformatf(" read_byte exp %02h got %02h", want.read_byte, got.read_byte)};
    if (got.tx_active !== want.tx_active)
      s = {s, $sformatf(" tx_active exp %0d got %0d", want.tx_active, got.tx_active)};
    if (got.rx_level !== want.rx_level)
      s = {s, $sformatf(" rx_level exp %0d got %0d", want.rx_level, got.rx_level)};
    if (got.tx_level !== want.tx_level)
      s = {s, $sformatf(" tx_level exp %0d got %0d", want.tx_level, got.tx_level)};
    if (got.dropped !== want.dropped)
      s = {s, $sformatf(" dropped exp %0d got %0d", want.dropped, got.dropped)};
    return s;
  endfunction

  // Counts a failure and reports only the first few.
  task automatic note_failure(string msg);
    err_count++;
    if (err_count <= MaxReports) begin
      $display("tb_top: error at cycle %0d:%s", cycle_count, msg);
    end
  endtask

  task automatic queue_event(cmd_e cmd, logic [ByteW-1:0] data, logic calm);
    uart_event_t ev;
    ev.drain = 1'b0;
    ev.calm  = calm;
    ev.cmd   = cmd;
    ev.data  = data;
    event_q.push_back(ev);
  endtask

  task automatic queue_drain();
    uart_event_t ev;
    ev.drain = 1'b1;
    ev.calm  = 1'b0;
    ev.cmd   = CmdRead;
    ev.data  = '0;
    event_q.push_back(ev);
  endtask

  // Byte values lean towards the extremes now and then.
  function automatic logic [ByteW-1:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return ByteW'($urandom_range(0, 255));
  endfunction

  function automatic cmd_e pick_cmd();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return CmdRxByte;
    if (r < 55) return CmdRead;
    if (r < 80) return CmdWrite;
    return CmdTxReady;
  endfunction

  // A mix of independent events.
  task automatic queue_mix(int unsigned n, logic calm);
    repeat (n) queue_event(pick_cmd(), pick_byte(), calm);
  endtask

  // Runs of one event kind, so that both rings swing between empty and well filled.
  task automatic queue_bursts(int unsigned n);
    cmd_e        cmd;
    int unsigned len;
    int unsigned done;
    done = 0;
    while (done < n) begin
      cmd = pick_cmd();
      len = $urandom_range(1, 24);
      repeat (len) queue_event(cmd, pick_byte(), 1'b0);
      done += len;
    end
  endtask

  // Stimulus, reset and end of run.
  initial begin
    req_if.valid = 1'b0;
    req_if.cmd   = CmdRxByte;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    rst_ni       = 1'b0;

    // Directed opening: empty read, masked ready, both extremes of the data byte.
    queue_event(CmdRead,    8'hFF, 1'b0);
    queue_event(CmdTxReady, 8'hA5, 1'b0);
    queue_event(CmdRxByte,  8'h00, 1'b0);
    queue_event(CmdRxByte,  8'hFF, 1'b0);
    queue_event(CmdRxByte,  8'h5A, 1'b0);
    queue_event(CmdRead,    8'h00, 1'b0);
    queue_event(CmdRead,    8'hFF, 1'b0);
    queue_event(CmdRead,    8'h00, 1'b0);
    queue_event(CmdRead,    8'h00, 1'b0);
    // Immediate send, two queued bytes, then drain and clear the active flag.
    queue_event(CmdWrite,   8'hFF, 1'b0);
    queue_event(CmdWrite,   8'h00, 1'b0);
    queue_event(CmdWrite,   8'h81, 1'b0);
    queue_event(CmdTxReady, 8'h00, 1'b0);
    queue_event(CmdTxReady, 8'hFF, 1'b0);
    queue_event(CmdTxReady, 8'h00, 1'b0);
    queue_event(CmdTxReady, 8'h00, 1'b0);
    queue_event(CmdWrite,   8'h00, 1'b0);
    queue_event(CmdTxReady, 8'h3C, 1'b0);
    queue_drain();

    queue_mix(250, 1'b0);

    // Receive ring overflow, then read it back past empty.
    queue_drain();
    repeat (260) queue_event(CmdRxByte, pick_byte(), 1'b0);
    repeat (270) queue_event(CmdRead, pick_byte(), 1'b0);

    // Transmit ring overflow, then drain it until the flag clears.
    repeat (261) queue_event(CmdWrite, pick_byte(), 1'b0);
    repeat (270) queue_event(CmdTxReady, pick_byte(), 1'b0);
    queue_drain();

    queue_bursts(300);
    queue_mix(120, 1'b1);

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every event has been taken and every result has arrived.
    do begin
      @(posedge clk_i);
    end while (event_q.size() != 0 || req_if.valid || owed_results_q.size() != 0);
    repeat (8) @(posedge clk_i);
    if (owed_results_q.size() != 0) begin
      note_failure($sformatf(" %0d results never arrived", owed_results_q.size()));
    end

    if (err_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Driver: presents the next event at the falling edge, with random gaps.
  always @(negedge clk_i) begin : drive_events
    uart_event_t nxt;
    logic        v;
    v = req_if.valid;
    if (!rst_ni) begin
      v = 1'b0;
    end else begin
      if (event_taken) begin
        v = 1'b0;
        event_taken = 1'b0;
      end
      if (!v) begin
        if (draining && owed_results_q.size() == 0) begin
          draining = 1'b0;
        end
        if (!draining) begin
          if (src_gap > 0) begin
            src_gap--;
          end else if (event_q.size() != 0) begin
            nxt = event_q.pop_front();
            if (nxt.drain) begin
              draining = 1'b1;
            end else begin
              v = 1'b1;
              drive_calm = nxt.calm;
              req_if.cmd  <= nxt.cmd;
              req_if.data <= nxt.data;
              if (!nxt.calm && $urandom_range(0, 7) == 0) begin
                src_gap = $urandom_range(1, 10);
              end
            end
          end
        end
      end
    end
    req_if.valid <= v;
  end

  // Receiver: stalls in random bursts, never in the closing stretch.
  always @(negedge clk_i) begin : drive_ready
    logic r;
    if (!rst_ni) begin
      r = 1'b0;
    end else if (calm_tail) begin
      r = 1'b1;
    end else if (sink_gap > 0) begin
      r = 1'b0;
      sink_gap--;
    end else begin
      r = 1'b1;
      if ($urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(1, 10);
      end
    end
    rsp_if.ready <= r;
  end

  // Monitor: checks each result transaction, then records the event taken at this edge.
  always @(posedge clk_i) begin : check_results
    uart_result_t got;
    uart_result_t want;
    string        diffs;
    cycle_count++;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.line_valid = rsp_if.line_valid;
        got.line_byte  = rsp_if.line_byte;
        got.read_valid = rsp_if.read_valid;
        got.read_byte  = rsp_if.read_byte;
        got.tx_active  = rsp_if.tx_active;
        got.rx_level   = rsp_if.rx_level;
        got.tx_level   = rsp_if.tx_level;
        got.dropped    = rsp_if.dropped;
        if (owed_results_q.size() == 0) begin
          note_failure(" result transaction with none expected");
        end else begin
          want  = owed_results_q.pop_front();
          diffs = field_diffs(got, want);
          if (diffs != "") begin
            note_failure(diffs);
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        owed_results_q.push_back(apply_uart_event(cmd_e'(req_if.cmd), req_if.data));
        calm_tail   = drive_calm;
        event_taken = 1'b1;
      end
    end
    if (cycle_count >= CycleLimit) begin
      $display("tb_top: timeout after %0d cycles", cycle_count);
      $display("tb_top: FAIL");
      $finish;
    end
  end

endmodule
